// File: src/gef_pkg.sv
// Shared types and constants for the 3x3 gradient edge filter.
// Used by the front end, the window queue, the back end and the top level.
package gef_pkg;

  localparam int NUM_CH        = 4;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // Operator codes
  localparam logic [1:0] MODE_ROBERTS = 2'd0;
  localparam logic [1:0] MODE_SOBEL   = 2'd1;
  localparam logic [1:0] MODE_PREWITT = 2'd2;
  localparam logic [1:0] MODE_LAPLACE = 2'd3;

  // Register indexes
  localparam logic [7:0] REG_EDGE_MODE     = 8'd0;
  localparam logic [7:0] REG_IMAGE_WIDTH   = 8'd1;
  localparam logic [7:0] REG_IMAGE_HEIGHT  = 8'd2;
  localparam logic [7:0] REG_CHANNEL_COUNT = 8'd3;

  // Register reset values
  localparam logic [1:0]  EDGE_MODE_RST     = MODE_SOBEL;
  localparam logic [11:0] IMAGE_WIDTH_RST   = 12'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST  = 12'd480;
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd1;

  // Largest sum of squares whose rounded root still fits in eight bits
  localparam logic [21:0] SQ_SAT_LIMIT = 22'd65280;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] width;
    logic [11:0] height;
    logic [2:0]  nch;
  } cfg_t;

  // Window item: index 0 top row, 1 middle row, 2 bottom row
  typedef struct packed {
    logic [2:0][31:0] lft;
    logic [2:0][31:0] ctr;
    logic [2:0][31:0] rgt;
    logic [3:0]       lane_en;
    logic             interior;
    logic             frame_end;
  } win_item_t;

  typedef struct packed {
    logic [3:0][7:0] edge_val;
    logic            interior;
    logic            frame_end;
  } result_t;

endpackage

// File: src/gradient_edge_filter_3x3_top.sv
// Top level of the 3x3 gradient edge filter: configuration registers and
// the front end, window queue and back end. Depends on gef_pkg.
// Path: line store read, stage one register, window queue, back end operator
// arithmetic, squares and root (gradient modes only), then the result register.
// The back end works on one item at a time, through the 8-step bit-serial square
// root in gradient modes; it takes the next item once its result is loaded.
// Reset: after rst the line store is cleared for MAX_WIDTH cycles with full high.
module gradient_edge_filter_3x3_top #(
  parameter int MAX_WIDTH = gef_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  chan0_sample,
  input  logic [7:0]  chan1_sample,
  input  logic [7:0]  chan2_sample,
  input  logic [7:0]  chan3_sample,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  chan0_edge,
  output logic [7:0]  chan1_edge,
  output logic [7:0]  chan2_edge,
  output logic [7:0]  chan3_edge,
  output logic        centre_interior,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gef_pkg::cfg_t      cfg;
  gef_pkg::win_item_t f_item;
  gef_pkg::win_item_t q_head;
  gef_pkg::result_t   res;
  logic                       f_push;
  logic                       q_pop;
  logic                       q_nonempty;
  logic [gef_pkg::QCNT_W-1:0] q_count;
  logic                       out_valid;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= gef_pkg::EDGE_MODE_RST;
      cfg.width  <= gef_pkg::IMAGE_WIDTH_RST;
      cfg.height <= gef_pkg::IMAGE_HEIGHT_RST;
      cfg.nch    <= gef_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gef_pkg::REG_EDGE_MODE:     cfg.mode   <= cfg_data[1:0];
        gef_pkg::REG_IMAGE_WIDTH:   cfg.width  <= cfg_data[11:0];
        gef_pkg::REG_IMAGE_HEIGHT:  cfg.height <= cfg_data[11:0];
        gef_pkg::REG_CHANNEL_COUNT: cfg.nch    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  gef_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .pix     ({chan3_sample, chan2_sample, chan1_sample, chan0_sample}),
    .full    (full),
    .q_count (q_count),
    .q_push  (f_push),
    .q_item  (f_item)
  );

  gef_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .item_in  (f_item),
    .pop      (q_pop),
    .item_out (q_head),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  gef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (cfg.mode),
    .q_nonempty (q_nonempty),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_res    (res),
    .out_pop    (pop)
  );

  assign empty           = !out_valid;
  assign chan0_edge      = res.edge_val[0];
  assign chan1_edge      = res.edge_val[1];
  assign chan2_edge      = res.edge_val[2];
  assign chan3_edge      = res.edge_val[3];
  assign centre_interior = res.interior;
  assign frame_end       = res.frame_end;

endmodule

// File: src/gef_front.sv
// Front end: position counters, line store with clearing pass, 3x3 window.
// Depends on gef_pkg for the configuration and window item types.
module gef_front #(
  parameter int MAX_WIDTH = gef_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gef_pkg::cfg_t             cfg,
  input  logic                      push,
  input  logic [31:0]               pix,
  output logic                      full,
  input  logic [gef_pkg::QCNT_W-1:0] q_count,
  output logic                      q_push,
  output gef_pkg::win_item_t        q_item
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CW-1:0] col;
  logic [11:0]   row;
  logic [63:0]   line_mem [MAX_WIDTH];
  logic [63:0]   rd_data;
  logic          clr_active;
  logic [CW-1:0] clr_addr;

  logic          s1_valid;
  logic [31:0]   s1_pix;
  logic [CW-1:0] s1_col;
  logic [3:0]    s1_en;
  logic          s1_int;
  logic          s1_fe;

  logic [2:0][31:0] win_prev;
  logic [2:0][31:0] win_prev2;
  logic [2:0][31:0] cur;

  logic [CW:0]   w_eff;
  logic [11:0]   h_eff;
  logic          last_col;
  logic          frame_end_c;
  logic          interior_c;
  logic [3:0]    lane_en_c;
  logic          accept;

  // Clamp the working frame size
  always_comb begin
    if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else if (cfg.width < 12'd3) begin
      w_eff = (CW+1)'(3);
    end else begin
      w_eff = (CW+1)'(cfg.width);
    end
    h_eff = (cfg.height < 12'd3) ? 12'd3 : cfg.height;
  end

  // Classify the incoming position
  always_comb begin
    last_col    = {1'b0, col} >= (w_eff - (CW+1)'(1));
    frame_end_c = last_col && (row >= (h_eff - 12'd1));
    interior_c  = (row >= 12'd2) && ({1'b0, col} >= (CW+1)'(2)) &&
                  (row <= (h_eff - 12'd1)) && ({1'b0, col} <= (w_eff - (CW+1)'(1)));
    for (int k = 0; k < gef_pkg::NUM_CH; k++) begin
      lane_en_c[k] = interior_c && (cfg.nch > 3'(k));
    end
  end

  // Hold off new items while clearing or when the queue may run out of room
  assign full   = clr_active ||
                  (((gef_pkg::QCNT_W+1)'(q_count) + (gef_pkg::QCNT_W+1)'(s1_valid)) >=
                   (gef_pkg::QCNT_W+1)'(gef_pkg::QUEUE_DEPTH));
  assign accept = push && !full;

  // Advance the column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col <= col + CW'(1);
      end else begin
        col <= '0;
        row <= frame_end_c ? 12'd0 : row + 12'd1;
      end
    end
  end

  // Sweep the line store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (32'(clr_addr) == MAX_WIDTH - 1) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + CW'(1);
      end
    end
  end

  // Line store: upper word newer row, lower word older row
  always_ff @(posedge clk) begin
    if (clr_active) begin
      line_mem[clr_addr] <= '0;
    end else if (s1_valid) begin
      line_mem[s1_col] <= {s1_pix, rd_data[63:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[col];
    end
  end

  // Stage one: hold the accepted item while the line store is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix;
      s1_col <= col;
      s1_en  <= lane_en_c;
      s1_int <= interior_c;
      s1_fe  <= frame_end_c;
    end
  end

  assign cur[0] = rd_data[31:0];
  assign cur[1] = rd_data[63:32];
  assign cur[2] = s1_pix;

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      win_prev  <= '0;
      win_prev2 <= '0;
    end else if (s1_valid) begin
      win_prev2 <= win_prev;
      win_prev  <= cur;
    end
  end

  assign q_push           = s1_valid;
  assign q_item.lft       = win_prev2;
  assign q_item.ctr       = win_prev;
  assign q_item.rgt       = cur;
  assign q_item.lane_en   = s1_en;
  assign q_item.interior  = s1_int;
  assign q_item.frame_end = s1_fe;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !clr_active)
    else $error("item entered during line store clearing");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before the line store read");

endmodule

// File: src/gef_queue.sv
// Short queue of window items between the front end and the back end.
// Depends on gef_pkg for the window item type and the queue depth.
module gef_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  gef_pkg::win_item_t         item_in,
  input  logic                       pop,
  output gef_pkg::win_item_t         item_out,
  output logic                       nonempty,
  output logic [gef_pkg::QCNT_W-1:0] count
);

  gef_pkg::win_item_t slots [gef_pkg::QUEUE_DEPTH];
  logic [gef_pkg::QPTR_W-1:0] wr_ptr;
  logic [gef_pkg::QPTR_W-1:0] rd_ptr;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gef_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gef_pkg::QPTR_W'(1);
      end
      count <= count + gef_pkg::QCNT_W'(push) - gef_pkg::QCNT_W'(pop);
    end
  end

  assign item_out = slots[rd_ptr];
  assign nonempty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < gef_pkg::QCNT_W'(gef_pkg::QUEUE_DEPTH))
    else $error("window queue overflow");

endmodule

// File: src/gef_back.sv
// Back end: operator arithmetic, bit-serial square root, result register.
// Depends on gef_pkg for the window item, result type and operator codes.
module gef_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         mode,
  input  logic               q_nonempty,
  input  gef_pkg::win_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  output gef_pkg::result_t   out_res,
  input  logic               out_pop
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQR  = 2'd1;
  localparam logic [1:0] B_ROOT = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0] state;

  logic [3:0]  en;
  logic        interior;
  logic        frame_end;
  logic signed [10:0] gx [gef_pkg::NUM_CH];
  logic signed [10:0] gy [gef_pkg::NUM_CH];
  logic signed [10:0] gx_c [gef_pkg::NUM_CH];
  logic signed [10:0] gy_c [gef_pkg::NUM_CH];
  logic [15:0] lap_c [gef_pkg::NUM_CH];
  logic [15:0] v [gef_pkg::NUM_CH];
  logic [15:0] res [gef_pkg::NUM_CH];
  logic [3:0]  sat;
  logic [15:0] bitr;
  logic [3:0][7:0] final_c;
  logic        load_out;

  // Operator arithmetic on the queue head, one lane per channel
  always_comb begin
    logic signed [10:0] tl, ml, bl, tc, mc, bc, tr, mr, br;
    logic signed [10:0] lap;
    logic signed [10:0] alap;
    for (int k = 0; k < gef_pkg::NUM_CH; k++) begin
      tl = {3'b000, q_item.lft[0][8*k +: 8]};
      ml = {3'b000, q_item.lft[1][8*k +: 8]};
      bl = {3'b000, q_item.lft[2][8*k +: 8]};
      tc = {3'b000, q_item.ctr[0][8*k +: 8]};
      mc = {3'b000, q_item.ctr[1][8*k +: 8]};
      bc = {3'b000, q_item.ctr[2][8*k +: 8]};
      tr = {3'b000, q_item.rgt[0][8*k +: 8]};
      mr = {3'b000, q_item.rgt[1][8*k +: 8]};
      br = {3'b000, q_item.rgt[2][8*k +: 8]};
      unique case (mode)
        gef_pkg::MODE_ROBERTS: begin
          gx_c[k] = mc - bc;
          gy_c[k] = mc - mr;
        end
        gef_pkg::MODE_SOBEL: begin
          gx_c[k] = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
          gy_c[k] = (tl + (tc <<< 1) + tr) - (bl + (bc <<< 1) + br);
        end
        default: begin
          gx_c[k] = (tr + mr + br) - (tl + ml + bl);
          gy_c[k] = (tl + tc + tr) - (bl + bc + br);
        end
      endcase
      lap  = (mc <<< 2) - tc - bc - ml - mr;
      alap = (lap < 0) ? -lap : lap;
      lap_c[k] = (alap > 11'sd255) ? 16'd255 : 16'(alap);
    end
  end

  // Round the root, saturate and mask disabled lanes
  always_comb begin
    logic [15:0] r;
    for (int k = 0; k < gef_pkg::NUM_CH; k++) begin
      r = (v[k] > res[k]) ? res[k] + 16'd1 : res[k];
      if (!en[k]) begin
        final_c[k] = 8'd0;
      end else if (sat[k]) begin
        final_c[k] = 8'd255;
      end else begin
        final_c[k] = r[7:0];
      end
    end
  end

  assign q_pop    = (state == B_IDLE) && q_nonempty;
  assign load_out = (state == B_DONE) && (!out_valid || out_pop);

  // Sequence one item through arithmetic and, for gradient modes, squares and root
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: if (q_nonempty) begin
          state <= (mode == gef_pkg::MODE_LAPLACE) ? B_DONE : B_SQR;
        end
        B_SQR:  state <= B_ROOT;
        B_ROOT: if (bitr == 16'd1) begin
          state <= B_DONE;
        end
        B_DONE: if (load_out) begin
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Lane datapath
  always_ff @(posedge clk) begin
    logic [21:0] px, py, sum;
    unique case (state)
      B_IDLE: if (q_nonempty) begin
        en        <= q_item.lane_en;
        interior  <= q_item.interior;
        frame_end <= q_item.frame_end;
        for (int k = 0; k < gef_pkg::NUM_CH; k++) begin
          gx[k]  <= gx_c[k];
          gy[k]  <= gy_c[k];
          res[k] <= lap_c[k];
          v[k]   <= 16'd0;
          sat[k] <= 1'b0;
        end
      end
      B_SQR: begin
        for (int k = 0; k < gef_pkg::NUM_CH; k++) begin
          px     = 22'(gx[k]) * 22'(gx[k]);
          py     = 22'(gy[k]) * 22'(gy[k]);
          sum    = px + py;
          sat[k] <= sum > gef_pkg::SQ_SAT_LIMIT;
          v[k]   <= sum[15:0];
          res[k] <= 16'd0;
        end
        bitr <= 16'h4000;
      end
      B_ROOT: begin
        for (int k = 0; k < gef_pkg::NUM_CH; k++) begin
          if (v[k] >= res[k] + bitr) begin
            v[k]   <= v[k] - (res[k] + bitr);
            res[k] <= (res[k] >> 1) + bitr;
          end else begin
            res[k] <= res[k] >> 1;
          end
        end
        bitr <= bitr >> 2;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res.edge_val  <= final_c;
      out_res.interior  <= interior;
      out_res.frame_end <= frame_end;
    end
  end

  a_root_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    state == B_ROOT |-> $onehot(bitr))
    else $error("root trial bit is not one-hot");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != B_IDLE)
    else $error("queue popped without starting an item");

endmodule

// File: tb/sv/gef_scoreboard.sv
// Result checker for the 3x3 gradient edge filter: it tracks register writes,
// predicts each result from the accepted pixels and compares the results.
// Depends on gef_pkg.
module gef_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  chan0_sample,
  input  logic [7:0]  chan1_sample,
  input  logic [7:0]  chan2_sample,
  input  logic [7:0]  chan3_sample,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  chan0_edge,
  input  logic [7:0]  chan1_edge,
  input  logic [7:0]  chan2_edge,
  input  logic [7:0]  chan3_edge,
  input  logic        centre_interior,
  input  logic        frame_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int LINE_LEN = gef_pkg::MAX_WIDTH_DEF;

  // Shadow registers
  logic [1:0]  mode_q;
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [2:0]  nch_q;

  // Shadow line stores, window and position
  logic [31:0] older_row [LINE_LEN];
  logic [31:0] newer_row [LINE_LEN];
  logic [31:0] col_prev  [3];
  logic [31:0] col_prev2 [3];
  int unsigned col_pos;
  int unsigned row_pos;

  gef_pkg::result_t expected_edges[$];

  assign pending = expected_edges.size();

  // Rounded magnitude of a gradient vector, saturated at 255
  function automatic logic [7:0] rounded_magnitude(int x, int y);
    int unsigned s;
    int unsigned r;
    s = x * x + y * y;
    r = 0;
    while (r < 256 && (r + 1) * (r + 1) <= s) r++;
    if (r < 256 && s > r * r + r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Edge value of one channel from its 3x3 neighborhood (rows t, m, b)
  function automatic logic [7:0] channel_edge(logic [1:0] mode,
      int tl, int tc, int tr, int ml, int mc, int mr, int bl, int bc, int br);
    int x;
    int y;
    int lap;
    int wt;
    case (mode)
      gef_pkg::MODE_ROBERTS: return rounded_magnitude(mc - bc, mc - mr);
      gef_pkg::MODE_LAPLACE: begin
        lap = 4 * mc - tc - bc - ml - mr;
        if (lap < 0) lap = -lap;
        return (lap > 255) ? 8'd255 : lap[7:0];
      end
      default: begin
        wt = (mode == gef_pkg::MODE_SOBEL) ? 2 : 1;
        x = (tr + wt * mr + br) - (tl + wt * ml + bl);
        y = (tl + wt * tc + tr) - (bl + wt * bc + br);
        return rounded_magnitude(x, y);
      end
    endcase
  endfunction

  // Advance the shadow filter by one pixel and return the expected result
  function automatic gef_pkg::result_t predict_edges(logic [31:0] pix);
    gef_pkg::result_t res;
    int unsigned w;
    int unsigned h;
    int unsigned nch;
    int unsigned c;
    logic [31:0] cur [3];
    logic inner;
    logic last_col;
    w = width_q;
    h = height_q;
    nch = nch_q;
    if (w < 3) w = 3;
    if (w > LINE_LEN) w = LINE_LEN;
    if (h < 3) h = 3;
    if (nch > 4) nch = 4;
    c = col_pos % LINE_LEN;
    cur[0] = older_row[c];
    cur[1] = newer_row[c];
    cur[2] = pix;
    inner = row_pos >= 2 && c >= 2 && row_pos <= h - 1 && c <= w - 1;
    for (int k = 0; k < 4; k++) begin
      res.edge_val[k] = 8'd0;
      if (inner && k < nch)
        res.edge_val[k] = channel_edge(mode_q,
          col_prev2[0][8*k +: 8], col_prev[0][8*k +: 8], cur[0][8*k +: 8],
          col_prev2[1][8*k +: 8], col_prev[1][8*k +: 8], cur[1][8*k +: 8],
          col_prev2[2][8*k +: 8], col_prev[2][8*k +: 8], cur[2][8*k +: 8]);
    end
    last_col = col_pos >= w - 1;
    res.interior = inner;
    res.frame_end = last_col && row_pos >= h - 1;
    older_row[c] = cur[1];
    newer_row[c] = pix;
    col_prev2 = col_prev;
    col_prev = cur;
    if (!last_col) begin
      col_pos++;
    end else begin
      col_pos = 0;
      row_pos = res.frame_end ? 0 : ((row_pos + 1) & 12'hFFF);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    gef_pkg::result_t got;
    gef_pkg::result_t want;
    if (rst) begin
      mode_q = gef_pkg::EDGE_MODE_RST;
      width_q = gef_pkg::IMAGE_WIDTH_RST;
      height_q = gef_pkg::IMAGE_HEIGHT_RST;
      nch_q = gef_pkg::CHANNEL_COUNT_RST;
      for (int i = 0; i < LINE_LEN; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        col_prev[i] = '0;
        col_prev2[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      expected_edges.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gef_pkg::REG_EDGE_MODE:     mode_q = cfg_data[1:0];
          gef_pkg::REG_IMAGE_WIDTH:   width_q = cfg_data[11:0];
          gef_pkg::REG_IMAGE_HEIGHT:  height_q = cfg_data[11:0];
          gef_pkg::REG_CHANNEL_COUNT: nch_q = cfg_data[2:0];
          default: ;
        endcase
      end
      // Predict on every accepted pixel
      if (push && !full)
        expected_edges.push_back(predict_edges({chan3_sample, chan2_sample,
                                                chan1_sample, chan0_sample}));
      // Compare every accepted result with the oldest prediction
      if (pop && !empty) begin
        got.edge_val = {chan3_edge, chan2_edge, chan1_edge, chan0_edge};
        got.interior = centre_interior;
        got.frame_end = frame_end;
        if (expected_edges.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %h", $realtime, got);
        end else begin
          want = expected_edges.pop_front();
          for (int k = 0; k < 4; k++)
            if (got.edge_val[k] !== want.edge_val[k]) begin
              errors++;
              $display("%0t: chan%0d_edge expected %0d actual %0d", $realtime, k,
                       want.edge_val[k], got.edge_val[k]);
            end
          if (got.interior !== want.interior) begin
            errors++;
            $display("%0t: centre_interior expected %0b actual %0b", $realtime,
                     want.interior, got.interior);
          end
          if (got.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $realtime,
                     want.frame_end, got.frame_end);
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule

// File: tb/sv/tb_gradient_edge_filter_3x3_top.sv
// Testbench top for the 3x3 gradient edge filter: clock, reset, pixel and
// register stimulus, result pacing and verdict. Depends on gef_pkg,
// gef_scoreboard and gradient_edge_filter_3x3_top.
module tb_gradient_edge_filter_3x3_top;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_TICKS = 30;
  localparam int RANDOM_PIXELS = 1450;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  chan0_sample, chan1_sample, chan2_sample, chan3_sample;
  logic        empty;
  logic        pop;
  logic [7:0]  chan0_edge, chan1_edge, chan2_edge, chan3_edge;
  logic        centre_interior;
  logic        frame_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  int errors;
  int pending;
  int send_gap_pct;
  int pop_stall_pct;
  int hold_request;
  int cycle_count;
  int random_sent;

  gradient_edge_filter_3x3_top i_dut (.*);

  gef_scoreboard i_scoreboard (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_gradient_edge_filter_3x3_top: errors");
      $finish;
    end
  end

  // Result pacing, with long hold-offs on request
  initial begin
    int hold_left;
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Push one pixel, with a random gap before it; called at a falling edge
  task automatic send_pixel(logic [31:0] pix);
    while ($urandom_range(99) < send_gap_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    {chan3_sample, chan2_sample, chan1_sample, chan0_sample} = pix;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain: wait for every expected result, then for the pipeline to settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] mode, logic [11:0] w, logic [11:0] h,
                            logic [2:0] nch);
    drain();
    write_reg(gef_pkg::REG_EDGE_MODE, {14'd0, mode});
    write_reg(gef_pkg::REG_IMAGE_WIDTH, {4'd0, w});
    write_reg(gef_pkg::REG_IMAGE_HEIGHT, {4'd0, h});
    write_reg(gef_pkg::REG_CHANNEL_COUNT, {13'd0, nch});
  endtask

  // Pick the idle pattern of a phase
  task automatic pick_idling(int sel);
    case (sel % 5)
      0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
      1: begin send_gap_pct = 54; pop_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  pop_stall_pct = 54; end
      3: begin send_gap_pct = 33; pop_stall_pct = 33; end
      default: begin send_gap_pct = 0; pop_stall_pct = 0; end
    endcase
  endtask

  function automatic logic [11:0] random_width();
    case ($urandom_range(19))
      0: return 12'($urandom_range(2));
      1: return 12'd4095;
      2: return 12'd2048;
      3: return 12'($urandom_range(4095));
      default: return 12'($urandom_range(3, 9));
    endcase
  endfunction

  function automatic logic [11:0] random_height();
    case ($urandom_range(19))
      0: return 12'($urandom_range(2));
      1: return 12'd4095;
      2: return 12'($urandom_range(4095));
      default: return 12'($urandom_range(3, 6));
    endcase
  endfunction

  // Pixel biased toward the extremes now and then
  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    p = $urandom;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(7))
        0: p[8*k +: 8] = 8'h00;
        1: p[8*k +: 8] = 8'hFF;
        default: ;
      endcase
    return p;
  endfunction

  initial begin
    int n;
    int phase;
    logic [11:0] w;
    logic [11:0] h;
    rst = 1'b1;
    push = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {chan3_sample, chan2_sample, chan1_sample, chan0_sample} = '0;
    send_gap_pct = 0;
    pop_stall_pct = 0;
    hold_request = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: checkerboard frame under Sobel, whose centre has zero gradient in every channel
    set_config(gef_pkg::MODE_SOBEL, 12'd3, 12'd3, 3'd4);
    for (int i = 0; i < 9; i++)
      send_pixel(((i % 2) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
    // Bright centre on a dark ring under Laplacian
    set_config(gef_pkg::MODE_LAPLACE, 12'd3, 12'd3, 3'd4);
    for (int i = 0; i < 9; i++)
      send_pixel((i == 4) ? 32'hFFFF_FFFF : 32'h0000_0000);
    // Roberts with two channels on and Prewitt with all channels off
    set_config(gef_pkg::MODE_ROBERTS, 12'd3, 12'd3, 3'd2);
    for (int i = 0; i < 4; i++) send_pixel(32'hFF00_FF00 ^ {32{i[0]}});
    set_config(gef_pkg::MODE_PREWITT, 12'd3, 12'd3, 3'd0);
    for (int i = 0; i < 3; i++) send_pixel(32'h00FF_00FF);

    // Random phases with random frame settings and random content
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_PIXELS) begin
      w = random_width();
      h = random_height();
      set_config(2'($urandom_range(3)), w, h, 3'($urandom_range(7)));
      pick_idling(phase);
      n = (w >= 3 && w <= 9 && h >= 3 && h <= 6) ? int'(w) * int'(h) * $urandom_range(1, 3)
                                                 : $urandom_range(20, 120);
      // Long receiver hold-off while the sender keeps pushing
      if (phase % 7 == 4) hold_request = 300;
      for (int i = 0; i < n; i++) send_pixel(random_pixel());
      random_sent += n;
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("tb_gradient_edge_filter_3x3_top: clean");
    end else begin
      $display("tb_gradient_edge_filter_3x3_top: errors");
    end
    $finish;
  end

endmodule
